FILE: rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared types, byte codes and defaults of the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 1024;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] CTL_SEQ0  = 8'h00;
  localparam logic [7:0] CTL_SEQ1  = 8'h40;
  localparam logic [7:0] REJ_SEQ0  = 8'h01;
  localparam logic [7:0] REJ_SEQ1  = 8'h81;
  localparam logic [7:0] RR_SEQ0   = 8'h05;
  localparam logic [7:0] RR_SEQ1   = 8'h85;

  localparam logic [7:0] ADDRESS_RST  = 8'd3;
  localparam logic [7:0] CHECK_RST    = 8'd3;
  localparam logic [7:0] EXP_CTL_RST  = 8'd7;

  typedef enum logic [1:0] {
    REG_ADDRESS  = 2'd0,
    REG_CHECK    = 2'd1,
    REG_EXP_CTL  = 2'd2,
    REG_INFO     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_FLAG = 3'd1,
    ST_ADDR = 3'd2,
    ST_CTRL = 3'd3,
    ST_DATA = 3'd4
  } state_t;

  typedef enum logic [2:0] {
    STS_ACK        = 3'd0,
    STS_REJECT     = 3'd1,
    STS_UNEXPECTED = 3'd2,
    STS_DATA_GOOD  = 3'd3,
    STS_DATA_BAD   = 3'd4,
    STS_OVERFLOW   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] address_byte;
    logic [7:0] check_address;
    logic [7:0] expected_control;
    logic       information_mode;
  } cfg_t;

  typedef struct packed {
    logic       frame_end;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic       sequence_bit;
    logic       reply_needed;
    logic [7:0] reply_control;
  } result_t;

endpackage

FILE: rtl/bsfr_decoder.sv
// ----------------------------------------------------------------------------
// bsfr_decoder
// Frame state and single-pass decode of one received byte: header checks,
// escape removal, one-byte payload delay, running XOR and end-of-frame status.
// ----------------------------------------------------------------------------
module bsfr_decoder #(
  parameter int unsigned MAX_FRAME_BYTES = bsfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  bsfr_pkg::cfg_t    cfg,
  output logic              res_valid,
  output bsfr_pkg::result_t res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  bsfr_pkg::state_t state, state_next;
  logic             frame_sequence, frame_sequence_next;
  logic [7:0]       running_parity, running_parity_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             held_valid, held_valid_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] stuffed_count, stuffed_count_next;

  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       hdr_ctl;
  logic [7:0]       v;
  logic             have_v;
  logic             good;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bsfr_pkg::ST_HUNT;
      frame_sequence <= 1'b0;
      running_parity <= '0;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      escape_pending <= 1'b0;
      stuffed_count  <= '0;
    end else if (step) begin
      state          <= state_next;
      frame_sequence <= frame_sequence_next;
      running_parity <= running_parity_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      escape_pending <= escape_pending_next;
      stuffed_count  <= stuffed_count_next;
    end
  end

  always_comb begin
    state_next          = state;
    frame_sequence_next = frame_sequence;
    running_parity_next = running_parity;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    escape_pending_next = escape_pending;
    stuffed_count_next  = stuffed_count;
    res_valid           = 1'b0;
    res                 = '0;
    cnt_inc             = stuffed_count + CNT_W'(1);
    hdr_ctl             = cfg.information_mode
                          ? (frame_sequence ? bsfr_pkg::CTL_SEQ1 : bsfr_pkg::CTL_SEQ0)
                          : cfg.expected_control;
    v                   = rx_byte;
    have_v              = 1'b0;
    good                = held_valid && (held_byte == running_parity);

    case (state)
      bsfr_pkg::ST_FLAG: begin
        if (rx_byte == cfg.address_byte) begin
          state_next = bsfr_pkg::ST_ADDR;
        end else if (rx_byte != bsfr_pkg::FLAG_BYTE) begin
          state_next = bsfr_pkg::ST_HUNT;
        end
      end
      bsfr_pkg::ST_ADDR: begin
        if (!cfg.information_mode) begin
          if (rx_byte == cfg.expected_control) begin
            state_next = bsfr_pkg::ST_CTRL;
          end else if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
            state_next = bsfr_pkg::ST_FLAG;
          end else begin
            state_next    = bsfr_pkg::ST_HUNT;
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
            res.status    = (rx_byte == bsfr_pkg::REJ_SEQ0 || rx_byte == bsfr_pkg::REJ_SEQ1)
                            ? bsfr_pkg::STS_REJECT : bsfr_pkg::STS_UNEXPECTED;
          end
        end else if (rx_byte == bsfr_pkg::CTL_SEQ0) begin
          frame_sequence_next = 1'b0;
          state_next          = bsfr_pkg::ST_CTRL;
        end else if (rx_byte == bsfr_pkg::CTL_SEQ1) begin
          frame_sequence_next = 1'b1;
          state_next          = bsfr_pkg::ST_CTRL;
        end else if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
          state_next = bsfr_pkg::ST_FLAG;
        end else begin
          state_next = bsfr_pkg::ST_HUNT;
        end
      end
      bsfr_pkg::ST_CTRL: begin
        if (rx_byte == (cfg.check_address ^ hdr_ctl)) begin
          state_next          = bsfr_pkg::ST_DATA;
          running_parity_next = '0;
          held_byte_next      = '0;
          held_valid_next     = 1'b0;
          escape_pending_next = 1'b0;
          stuffed_count_next  = '0;
        end else begin
          state_next = bsfr_pkg::ST_HUNT;
        end
      end
      bsfr_pkg::ST_DATA: begin
        if (!cfg.information_mode || rx_byte == bsfr_pkg::FLAG_BYTE ||
            cnt_inc == CNT_MAX) begin
          state_next          = bsfr_pkg::ST_HUNT;
          running_parity_next = '0;
          held_byte_next      = '0;
          held_valid_next     = 1'b0;
          escape_pending_next = 1'b0;
          stuffed_count_next  = '0;
          if (!cfg.information_mode) begin
            if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
              res_valid     = 1'b1;
              res.frame_end = 1'b1;
              res.status    = bsfr_pkg::STS_ACK;
            end
          end else if (rx_byte == bsfr_pkg::FLAG_BYTE) begin
            res_valid         = 1'b1;
            res.frame_end     = 1'b1;
            res.status        = good ? bsfr_pkg::STS_DATA_GOOD : bsfr_pkg::STS_DATA_BAD;
            res.sequence_bit  = frame_sequence;
            res.reply_needed  = 1'b1;
            if (good) begin
              res.reply_control = frame_sequence ? bsfr_pkg::RR_SEQ1 : bsfr_pkg::RR_SEQ0;
            end else begin
              res.reply_control = frame_sequence ? bsfr_pkg::REJ_SEQ1 : bsfr_pkg::REJ_SEQ0;
            end
          end else begin
            res_valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.status       = bsfr_pkg::STS_OVERFLOW;
            res.sequence_bit = frame_sequence;
          end
        end else begin
          stuffed_count_next = cnt_inc;
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (rx_byte == bsfr_pkg::ESC_FLAG) begin
              v      = bsfr_pkg::FLAG_BYTE;
              have_v = 1'b1;
            end else if (rx_byte == bsfr_pkg::ESC_ESC) begin
              v      = bsfr_pkg::ESC_BYTE;
              have_v = 1'b1;
            end
          end else if (rx_byte == bsfr_pkg::ESC_BYTE) begin
            escape_pending_next = 1'b1;
          end else begin
            have_v = 1'b1;
          end
          if (have_v) begin
            held_byte_next  = v;
            held_valid_next = 1'b1;
            if (held_valid) begin
              res_valid           = 1'b1;
              res.payload_byte    = held_byte;
              res.sequence_bit    = frame_sequence;
              running_parity_next = running_parity ^ held_byte;
            end
          end
        end
      end
      default: begin
        state_next = (rx_byte == bsfr_pkg::FLAG_BYTE) ? bsfr_pkg::ST_FLAG : bsfr_pkg::ST_HUNT;
      end
    endcase
  end

endmodule

FILE: rtl/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Receives byte-stuffed HDLC-style frames one byte per request, checks the
// header, removes escapes and reports payload bytes and end-of-frame status.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle in steady state unless the output stalls. A
// byte goes into an input register, is decoded in one pass against the frame
// state, and its result (if any) goes into the output register. Throughput is
// set by the output register alone: while it holds an untaken result the next
// byte waits in the input register, and input ready drops once both are full.
// Configuration writes are always accepted and take effect on the next byte.
module byte_stuffed_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = bsfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_end,
  output logic [7:0] payload_byte,
  output logic [2:0] status,
  output logic       sequence_bit,
  output logic       reply_needed,
  output logic [7:0] reply_control
);

  bsfr_pkg::cfg_t    cfg;
  logic              in_full;
  logic [7:0]        in_byte;
  logic              step;
  logic              res_valid;
  bsfr_pkg::result_t res;
  bsfr_pkg::result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_byte     <= bsfr_pkg::ADDRESS_RST;
      cfg.check_address    <= bsfr_pkg::CHECK_RST;
      cfg.expected_control <= bsfr_pkg::EXP_CTL_RST;
      cfg.information_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (bsfr_pkg::reg_index_t'(cfg_index))
        bsfr_pkg::REG_ADDRESS: cfg.address_byte     <= cfg_data;
        bsfr_pkg::REG_CHECK:   cfg.check_address    <= cfg_data;
        bsfr_pkg::REG_EXP_CTL: cfg.expected_control <= cfg_data;
        bsfr_pkg::REG_INFO:    cfg.information_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  bsfr_decoder #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign frame_end     = out_res.frame_end;
  assign payload_byte  = out_res.payload_byte;
  assign status        = out_res.status;
  assign sequence_bit  = out_res.sequence_bit;
  assign reply_needed  = out_res.reply_needed;
  assign reply_control = out_res.reply_control;

  // stalled result with a byte waiting must block the input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_reply_only_on_data_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (reply_needed ==
      (frame_end && (status == bsfr_pkg::STS_DATA_GOOD ||
                     status == bsfr_pkg::STS_DATA_BAD))))
    else $error("reply flag inconsistent with status");

  a_payload_plain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> (status == bsfr_pkg::STS_ACK && reply_control == 8'h00))
    else $error("payload result carries status");

  a_reply_seq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reply_needed) |-> (reply_control[7] == sequence_bit))
    else $error("reply control does not match sequence bit");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for byte_stuffed_frame_receiver: a per-byte frame
// decoder in the bench predicts every payload byte and end-of-frame status
// from the bytes the block accepts. It covers supervisory and information
// frames, escapes, broken headers, line noise, the length limit, output
// back-pressure and register changes, also one made with a header half received.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LIMIT = bsfr_pkg::MAX_FRAME_BYTES_DEF;
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES = 60;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       frame_end;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       sequence_bit;
  logic       reply_needed;
  logic [7:0] reply_control;

  // register mirror
  logic [7:0] m_addr = bsfr_pkg::ADDRESS_RST;
  logic [7:0] m_chk  = bsfr_pkg::CHECK_RST;
  logic [7:0] m_ctl  = bsfr_pkg::EXP_CTL_RST;
  logic       m_info = 1'b0;

  // frame decoder state
  bsfr_pkg::state_t fr_state = bsfr_pkg::ST_HUNT;
  logic        fr_seq = 1'b0;
  logic [7:0]  fr_xor = '0;
  logic [7:0]  fr_held = '0;
  logic        fr_held_ok = 1'b0;
  logic        fr_esc = 1'b0;
  int unsigned fr_count = 0;

  bsfr_pkg::result_t results_due[$];
  logic [7:0]  frame_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        out_hold = 1'b0;
  event        hold_go;

  byte_stuffed_frame_receiver #(.MAX_FRAME_BYTES(FRAME_LIMIT)) uut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("mismatch %s: got %02h want %02h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic void clear_frame();
    fr_xor = '0;
    fr_held = '0;
    fr_held_ok = 1'b0;
    fr_esc = 1'b0;
    fr_count = 0;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    bsfr_pkg::result_t r;
    logic [7:0] ctl;
    logic [7:0] v;
    logic       good;
    logic       emit;
    logic       have;
    r = '0;
    have = 1'b0;
    case (fr_state)
      bsfr_pkg::ST_FLAG: begin
        if (b == m_addr) fr_state = bsfr_pkg::ST_ADDR;
        else if (b != bsfr_pkg::FLAG_BYTE) fr_state = bsfr_pkg::ST_HUNT;
      end
      bsfr_pkg::ST_ADDR: begin
        if (!m_info) begin
          if (b == m_ctl) begin
            fr_state = bsfr_pkg::ST_CTRL;
          end else if (b == bsfr_pkg::FLAG_BYTE) begin
            fr_state = bsfr_pkg::ST_FLAG;
          end else begin
            fr_state = bsfr_pkg::ST_HUNT;
            have = 1'b1;
            r.frame_end = 1'b1;
            r.status = (b == bsfr_pkg::REJ_SEQ0 || b == bsfr_pkg::REJ_SEQ1)
                       ? bsfr_pkg::STS_REJECT : bsfr_pkg::STS_UNEXPECTED;
          end
        end else if (b == bsfr_pkg::CTL_SEQ0) begin
          fr_seq = 1'b0;
          fr_state = bsfr_pkg::ST_CTRL;
        end else if (b == bsfr_pkg::CTL_SEQ1) begin
          fr_seq = 1'b1;
          fr_state = bsfr_pkg::ST_CTRL;
        end else if (b == bsfr_pkg::FLAG_BYTE) begin
          fr_state = bsfr_pkg::ST_FLAG;
        end else begin
          fr_state = bsfr_pkg::ST_HUNT;
        end
      end
      bsfr_pkg::ST_CTRL: begin
        ctl = m_info ? (fr_seq ? bsfr_pkg::CTL_SEQ1 : bsfr_pkg::CTL_SEQ0) : m_ctl;
        if (b == (m_chk ^ ctl)) begin
          fr_state = bsfr_pkg::ST_DATA;
          clear_frame();
        end else begin
          fr_state = bsfr_pkg::ST_HUNT;
        end
      end
      bsfr_pkg::ST_DATA: begin
        if (!m_info) begin
          fr_state = bsfr_pkg::ST_HUNT;
          clear_frame();
          if (b == bsfr_pkg::FLAG_BYTE) begin
            have = 1'b1;
            r.frame_end = 1'b1;
            r.status = bsfr_pkg::STS_ACK;
          end
        end else if (b == bsfr_pkg::FLAG_BYTE) begin
          good = fr_held_ok && (fr_held == fr_xor);
          have = 1'b1;
          r.frame_end = 1'b1;
          r.status = good ? bsfr_pkg::STS_DATA_GOOD : bsfr_pkg::STS_DATA_BAD;
          r.sequence_bit = fr_seq;
          r.reply_needed = 1'b1;
          if (good) r.reply_control = fr_seq ? bsfr_pkg::RR_SEQ1 : bsfr_pkg::RR_SEQ0;
          else r.reply_control = fr_seq ? bsfr_pkg::REJ_SEQ1 : bsfr_pkg::REJ_SEQ0;
          fr_state = bsfr_pkg::ST_HUNT;
          clear_frame();
        end else begin
          fr_count++;
          if (fr_count >= FRAME_LIMIT) begin
            have = 1'b1;
            r.frame_end = 1'b1;
            r.status = bsfr_pkg::STS_OVERFLOW;
            r.sequence_bit = fr_seq;
            fr_state = bsfr_pkg::ST_HUNT;
            clear_frame();
          end else begin
            emit = 1'b1;
            v = b;
            if (fr_esc) begin
              fr_esc = 1'b0;
              if (b == bsfr_pkg::ESC_FLAG) v = bsfr_pkg::FLAG_BYTE;
              else if (b == bsfr_pkg::ESC_ESC) v = bsfr_pkg::ESC_BYTE;
              else emit = 1'b0;
            end else if (b == bsfr_pkg::ESC_BYTE) begin
              fr_esc = 1'b1;
              emit = 1'b0;
            end
            if (emit) begin
              if (fr_held_ok) begin
                have = 1'b1;
                r.payload_byte = fr_held;
                r.sequence_bit = fr_seq;
                fr_xor ^= fr_held;
              end
              fr_held = v;
              fr_held_ok = 1'b1;
            end
          end
        end
      end
      default: fr_state = (b == bsfr_pkg::FLAG_BYTE) ? bsfr_pkg::ST_FLAG : bsfr_pkg::ST_HUNT;
    endcase
    if (have) results_due.push_back(r);
  endtask

  // one request on the byte channel; valid stays up for a back-to-back request
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) send_byte(frame_q[k]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bsfr_pkg::reg_index_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bsfr_pkg::REG_ADDRESS: m_addr = val;
      bsfr_pkg::REG_CHECK:   m_chk = val;
      bsfr_pkg::REG_EXP_CTL: m_ctl = val;
      default:               m_info = val[0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [7:0] a, input logic [7:0] c,
                              input logic [7:0] e, input logic i);
    wait_idle();
    write_reg(bsfr_pkg::REG_ADDRESS, a);
    write_reg(bsfr_pkg::REG_CHECK, c);
    write_reg(bsfr_pkg::REG_EXP_CTL, e);
    write_reg(bsfr_pkg::REG_INFO, {7'b0, i});
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] payload_value();
    case ($urandom_range(15))
      0: return bsfr_pkg::FLAG_BYTE;
      1: return bsfr_pkg::ESC_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_stuffed(input logic [7:0] v);
    if (v == bsfr_pkg::FLAG_BYTE) begin
      frame_q.push_back(bsfr_pkg::ESC_BYTE);
      frame_q.push_back(bsfr_pkg::ESC_FLAG);
    end else if (v == bsfr_pkg::ESC_BYTE) begin
      frame_q.push_back(bsfr_pkg::ESC_BYTE);
      frame_q.push_back(bsfr_pkg::ESC_ESC);
    end else begin
      frame_q.push_back(v);
    end
  endfunction

  // appends an information frame, now and then with a fault in its tail
  task automatic build_info_frame(input int len);
    logic [7:0] c;
    logic [7:0] x;
    logic [7:0] v;
    int         fault;
    c = $urandom_range(1) ? bsfr_pkg::CTL_SEQ1 : bsfr_pkg::CTL_SEQ0;
    x = '0;
    fault = $urandom_range(9);
    frame_q.push_back(bsfr_pkg::FLAG_BYTE);
    frame_q.push_back(m_addr);
    frame_q.push_back(c);
    frame_q.push_back(m_chk ^ c);
    repeat (len) begin
      v = payload_value();
      x ^= v;
      push_stuffed(v);
    end
    if (fault == 0) x ^= 8'($urandom_range(1, 255));
    if (fault == 1) begin
      // escape with an unknown follower: both dropped
      do v = 8'($urandom_range(255));
      while (v == bsfr_pkg::ESC_FLAG || v == bsfr_pkg::ESC_ESC || v == bsfr_pkg::FLAG_BYTE);
      frame_q.push_back(bsfr_pkg::ESC_BYTE);
      frame_q.push_back(v);
    end
    if (fault != 2) push_stuffed(x);
    if (fault == 3) frame_q.push_back(bsfr_pkg::ESC_BYTE);
    frame_q.push_back(bsfr_pkg::FLAG_BYTE);
  endtask

  task automatic build_random_frame();
    int         kind;
    int         r;
    logic [7:0] c;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(7);
        if (r == 0) frame_q.push_back(bsfr_pkg::FLAG_BYTE);
        else if (r == 1) frame_q.push_back(m_addr);
        else if (r == 2) frame_q.push_back(bsfr_pkg::ESC_BYTE);
        else frame_q.push_back(8'($urandom_range(255)));
      end
    end else if (kind < 25) begin
      c = m_info ? bsfr_pkg::CTL_SEQ0 : m_ctl;
      frame_q.push_back(bsfr_pkg::FLAG_BYTE);
      frame_q.push_back($urandom_range(1) ? m_addr : 8'($urandom_range(255)));
      frame_q.push_back(c);
      frame_q.push_back(m_chk ^ c ^ 8'($urandom_range(1, 255)));
      frame_q.push_back(8'($urandom_range(255)));
    end else if (m_info) begin
      build_info_frame(($urandom_range(3) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 14));
    end else begin
      r = $urandom_range(9);
      if (r < 6) c = m_ctl;
      else if (r == 6) c = bsfr_pkg::REJ_SEQ0;
      else if (r == 7) c = bsfr_pkg::REJ_SEQ1;
      else if (r == 8) c = 8'($urandom_range(255));
      else c = bsfr_pkg::FLAG_BYTE;
      frame_q.push_back(bsfr_pkg::FLAG_BYTE);
      frame_q.push_back(m_addr);
      frame_q.push_back(c);
      if (c == m_ctl) begin
        frame_q.push_back(m_chk ^ m_ctl);
        frame_q.push_back($urandom_range(4) ? bsfr_pkg::FLAG_BYTE : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_supervisory();
    frame_q = '{bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE, m_addr, m_ctl, m_chk ^ m_ctl,
                bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE, m_addr, m_ctl,
                bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE, m_addr, bsfr_pkg::REJ_SEQ1,
                bsfr_pkg::FLAG_BYTE, m_addr, bsfr_pkg::FLAG_BYTE, m_addr, 8'hFF,
                bsfr_pkg::FLAG_BYTE, m_addr, m_ctl, m_chk ^ m_ctl, 8'h00};
    send_frame();
  endtask

  task automatic test_info_frame();
    frame_q = '{bsfr_pkg::FLAG_BYTE, m_addr};
    send_frame();
    // mode switch with the header half received
    wait_idle();
    write_reg(bsfr_pkg::REG_INFO, 8'h01);
    frame_q = '{bsfr_pkg::CTL_SEQ1, m_chk ^ bsfr_pkg::CTL_SEQ1,
                bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_FLAG, bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_ESC,
                bsfr_pkg::ESC_BYTE, 8'h11, 8'h03, bsfr_pkg::FLAG_BYTE,
                bsfr_pkg::FLAG_BYTE, m_addr, bsfr_pkg::CTL_SEQ0, m_chk ^ bsfr_pkg::CTL_SEQ0,
                bsfr_pkg::FLAG_BYTE,
                bsfr_pkg::FLAG_BYTE, m_addr, bsfr_pkg::CTL_SEQ0, m_chk ^ bsfr_pkg::CTL_SEQ0,
                8'h55, bsfr_pkg::ESC_BYTE, bsfr_pkg::FLAG_BYTE};
    send_frame();
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned frames;
    sent = 0;
    frames = 0;
    while (sent < n) begin
      build_random_frame();
      send_frame();
      sent += frame_q.size();
      frames++;
      if (frames % 12 == 0)
        apply_config(edge_byte(), edge_byte(), edge_byte(), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_backpressure();
    apply_config(m_addr, m_chk, m_ctl, 1'b1);
    frame_q.delete();
    build_info_frame(48);
    -> hold_go;
    send_frame();
    wait_idle();
  endtask

  task automatic test_length_limit();
    logic [7:0] v;
    apply_config(m_addr, m_chk, m_ctl, 1'b1);
    frame_q.delete();
    // one frame just under the limit, one running past it
    for (int f = 0; f < 2; f++) begin
      frame_q = '{bsfr_pkg::FLAG_BYTE, m_addr, bsfr_pkg::CTL_SEQ0,
                  m_chk ^ bsfr_pkg::CTL_SEQ0};
      repeat (FRAME_LIMIT - 1 + 7 * f) begin
        do v = 8'($urandom_range(255));
        while (v == bsfr_pkg::FLAG_BYTE || v == bsfr_pkg::ESC_BYTE);
        frame_q.push_back(v);
      end
      frame_q.push_back(bsfr_pkg::FLAG_BYTE);
      send_frame();
    end
  endtask

  always begin
    @(hold_go);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    bsfr_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none due", payload_byte, 8'h00);
      end else begin
        want = results_due.pop_front();
        if (frame_end !== want.frame_end)
          report_mismatch("frame_end", frame_end, want.frame_end);
        if (payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", payload_byte, want.payload_byte);
        if (status !== want.status)
          report_mismatch("status", status, want.status);
        if (sequence_bit !== want.sequence_bit)
          report_mismatch("sequence_bit", sequence_bit, want.sequence_bit);
        if (reply_needed !== want.reply_needed)
          report_mismatch("reply_needed", reply_needed, want.reply_needed);
        if (reply_control !== want.reply_control)
          report_mismatch("reply_control", reply_control, want.reply_control);
      end
    end
    out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 22;
    recv_idle_pct <= 64;
    test_supervisory();
    test_info_frame();
    apply_config(8'h00, 8'hFF, 8'hFF, 1'b1);
    test_random_traffic(180);
    wait_idle();
    send_idle_pct = 64;
    recv_idle_pct <= 22;
    apply_config(8'hFF, 8'h00, 8'h00, 1'b0);
    test_random_traffic(180);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_random_traffic(190);
    test_length_limit();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
